FILE: rtl/lmsp_pkg.sv
package lmsp_pkg;

	// Fixed panel geometry and field widths.
	localparam int PANEL_ROWS = 32;
	localparam int HALF_ROWS  = PANEL_ROWS / 2;
	localparam int ROW_W      = 4;
	localparam int PLANE_W    = 4;
	localparam int LEVEL_W    = 5;
	localparam int BYTE_W     = 8;
	localparam int COLOR_W    = 6;
	localparam int CHAN_W     = 2;

	// Input item kinds.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Color channel codes, in the order the bytes arrive.
	localparam logic [CHAN_W-1:0] CH_RED   = 2'd0;
	localparam logic [CHAN_W-1:0] CH_GREEN = 2'd1;
	localparam logic [CHAN_W-1:0] CH_BLUE  = 2'd2;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_SCAN,
		CTL_DRAIN
	} ctl_state_t;

	typedef struct packed {
		logic write_px;    // store one pixel byte
		logic start_scan;  // clear the column counter
		logic issue;       // read one column and push it down the pipe
		logic finish;      // step row and plane counters
	} ctl_cmd_t;

	typedef struct packed {
		logic frame_ready;
		logic advance;     // pipe may move this cycle
		logic col_last;    // column counter is on the final column
	} dp_status_t;

endpackage

FILE: rtl/lmsp_ctrl.sv
module lmsp_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	input  logic                  op,
	input  lmsp_pkg::dp_status_t  status,
	output logic                  item_stall,
	output lmsp_pkg::ctl_cmd_t    cmd
);

	lmsp_pkg::ctl_state_t state_q;
	lmsp_pkg::ctl_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lmsp_pkg::CTL_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		item_stall = 1'b1;
		cmd        = '0;
		case (state_q)
			lmsp_pkg::CTL_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					if (op == lmsp_pkg::OP_PIXEL) begin
						cmd.write_px = 1'b1;
					end else if (status.frame_ready) begin
						// A tick before the first full frame is taken and dropped.
						cmd.start_scan = 1'b1;
						state_next     = lmsp_pkg::CTL_SCAN;
					end
				end
			end
			lmsp_pkg::CTL_SCAN: begin
				if (status.advance) begin
					cmd.issue = 1'b1;
					if (status.col_last) begin
						state_next = lmsp_pkg::CTL_DRAIN;
					end
				end
			end
			lmsp_pkg::CTL_DRAIN: begin
				// The final column moves into the output register here.
				if (status.advance) begin
					cmd.finish = 1'b1;
					state_next = lmsp_pkg::CTL_IDLE;
				end
			end
			default: begin
				state_next = lmsp_pkg::CTL_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/lmsp_datapath.sv
module lmsp_datapath #(
	parameter int COLUMNS = 32,
	parameter int LEVELS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  lmsp_pkg::ctl_cmd_t                   cmd,
	input  logic [lmsp_pkg::BYTE_W-1:0]          pixel_byte,
	input  logic                                 result_stall,
	output lmsp_pkg::dp_status_t                 status,
	output logic                                 result_valid,
	output logic [lmsp_pkg::COLOR_W-1:0]         color_bits,
	output logic [lmsp_pkg::ROW_W-1:0]           row_address,
	output logic                                 last
);

	localparam int PIX_COUNT = COLUMNS * lmsp_pkg::PANEL_ROWS;
	localparam int PIX_W     = $clog2(PIX_COUNT);
	localparam int ADDR_W    = PIX_W + 1;
	localparam int MEM_DEPTH = 2 ** ADDR_W;
	localparam int COL_W     = $clog2(COLUMNS);
	localparam int BOT_OFS   = lmsp_pkg::HALF_ROWS * COLUMNS;

	// Fill side.
	logic [PIX_W-1:0]                pix_q;
	logic [lmsp_pkg::CHAN_W-1:0]     chan_q;
	logic                            shown_half_q;
	logic                            frame_ready_q;
	logic                            frame_done;
	logic [lmsp_pkg::LEVEL_W-1:0]    level;
	logic [ADDR_W-1:0]               wr_addr;
	logic [2:0]                      chan_we;

	// Scan side.
	logic [lmsp_pkg::ROW_W-1:0]      scan_row_q;
	logic [lmsp_pkg::PLANE_W-1:0]    plane_q;
	logic [COL_W-1:0]                col_q;
	logic [PIX_W-1:0]                top_pix;
	logic [ADDR_W-1:0]               top_addr;
	logic [ADDR_W-1:0]               bot_addr;
	logic                            advance;
	logic                            valid_s1;
	logic                            last_s1;
	logic [2:0]                      lit_top;
	logic [2:0]                      lit_bot;
	logic                            result_valid_q;
	logic [lmsp_pkg::COLOR_W-1:0]    color_bits_q;
	logic [lmsp_pkg::ROW_W-1:0]      row_address_q;
	logic                            last_q;

	assign level = (pixel_byte > lmsp_pkg::BYTE_W'(LEVELS)) ?
		lmsp_pkg::LEVEL_W'(LEVELS) : lmsp_pkg::LEVEL_W'(pixel_byte);
	assign wr_addr    = {~shown_half_q, pix_q};
	assign frame_done = cmd.write_px && (chan_q == lmsp_pkg::CH_BLUE) &&
		(pix_q == PIX_W'(PIX_COUNT - 1));

	assign chan_we[0] = cmd.write_px && (chan_q == lmsp_pkg::CH_RED);
	assign chan_we[1] = cmd.write_px && (chan_q == lmsp_pkg::CH_GREEN);
	assign chan_we[2] = cmd.write_px && (chan_q == lmsp_pkg::CH_BLUE);

	assign top_pix  = PIX_W'(scan_row_q) * PIX_W'(COLUMNS) + PIX_W'(col_q);
	assign top_addr = {shown_half_q, top_pix};
	assign bot_addr = {shown_half_q, top_pix + PIX_W'(BOT_OFS)};

	assign advance = !result_valid_q || !result_stall;

	assign status.frame_ready = frame_ready_q;
	assign status.advance     = advance;
	assign status.col_last    = (col_q == COL_W'(COLUMNS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q         <= '0;
			chan_q        <= lmsp_pkg::CH_RED;
			shown_half_q  <= 1'b0;
			frame_ready_q <= 1'b0;
			scan_row_q    <= '0;
			plane_q       <= '0;
		end else if (cmd.write_px) begin
			if (chan_q == lmsp_pkg::CH_BLUE) begin
				chan_q <= lmsp_pkg::CH_RED;
				pix_q  <= frame_done ? '0 : pix_q + 1'b1;
			end else begin
				chan_q <= chan_q + 1'b1;
			end
			if (frame_done) begin
				// Whole frame in: show it and restart the scan from the top.
				shown_half_q  <= ~shown_half_q;
				frame_ready_q <= 1'b1;
				scan_row_q    <= '0;
				plane_q       <= '0;
			end
		end else if (cmd.finish) begin
			if (scan_row_q == lmsp_pkg::ROW_W'(lmsp_pkg::HALF_ROWS - 1)) begin
				scan_row_q <= '0;
				plane_q    <= (plane_q == lmsp_pkg::PLANE_W'(LEVELS - 1)) ?
					'0 : plane_q + 1'b1;
			end else begin
				scan_row_q <= scan_row_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (cmd.start_scan) begin
			col_q <= '0;
		end else if (cmd.issue && !status.col_last) begin
			col_q <= col_q + 1'b1;
		end
	end

	// One store per color channel; each is read at the top and bottom pixel.
	for (genvar ch = 0; ch < 3; ch++) begin : g_chan
		logic [lmsp_pkg::LEVEL_W-1:0] mem [MEM_DEPTH];
		logic [lmsp_pkg::LEVEL_W-1:0] top_lvl_s1;
		logic [lmsp_pkg::LEVEL_W-1:0] bot_lvl_s1;

		always_ff @(posedge clk) begin
			if (chan_we[ch]) begin
				mem[wr_addr] <= level;
			end
			if (cmd.issue) begin
				top_lvl_s1 <= mem[top_addr];
				bot_lvl_s1 <= mem[bot_addr];
			end
		end

		assign lit_top[ch] = top_lvl_s1 > {1'b0, plane_q};
		assign lit_bot[ch] = bot_lvl_s1 > {1'b0, plane_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1       <= cmd.issue;
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			last_s1 <= status.col_last;
		end
		if (advance && valid_s1) begin
			color_bits_q  <= {lit_bot, lit_top};
			row_address_q <= last_s1 ? scan_row_q : '0;
			last_q        <= last_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign color_bits   = color_bits_q;
	assign row_address  = row_address_q;
	assign last         = last_q;

	a_issue_needs_frame: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> frame_ready_q)
		else $error("column read issued with no frame shown");

	a_no_write_during_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_px |-> !valid_s1 && !cmd.issue)
		else $error("pixel write overlaps a row scan");

	a_row_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q && !last_q |-> row_address_q == '0)
		else $error("row address set on a column that is not the last");

	a_plane_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		plane_q < lmsp_pkg::PLANE_W'(LEVELS - 1) ||
		plane_q == lmsp_pkg::PLANE_W'(LEVELS - 1))
		else $error("brightness plane out of range");

	a_frame_swap_clears: assert property (@(posedge clk) disable iff (!arst_n)
		frame_done |=> scan_row_q == '0 && plane_q == '0 && frame_ready_q)
		else $error("frame swap did not restart the scan");

endmodule

FILE: rtl/rgb_led_matrix_scan_pwm_core.sv
// RGB LED matrix scanner for a 32-row two-half panel with brightness planes.
// Input channel (item_valid / item_stall): op selects the word kind. A pixel
// word (op = 0) carries one color byte, R,G,B order, row-major; it is clamped
// to LEVELS and written into the back frame buffer. When a whole frame is in,
// the buffers swap and the row and plane counters restart.
// A tick word (op = 1) scans one row pair out as COLUMNS result words on the
// result channel (result_valid / result_stall): color_bits holds top R,G,B in
// bits 0-2 and bottom R,G,B in bits 3-5; the final word has last set and
// carries row_address. A tick before the first full frame yields nothing.
// Pixel words are taken at one per cycle while idle. A tick stalls the input
// until the row is scanned out, paced by one column read per cycle from the
// frame buffers while the receiver does not stall; each column passes through
// the stage-one registers and then the output register.
// When the receiver stalls, the output register holds its word and the column
// pipe freezes; no word is lost. The input is taken again as soon as the last
// column has reached the output register, even while it still waits there.
// Reset clears all counters and the valid and frame-ready flags; the frame buffers
// are not cleared and no buffer is shown until a full frame has been written.
module rgb_led_matrix_scan_pwm_core #(
	parameter int COLUMNS = 32,
	parameter int LEVELS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic                           op,
	input  logic [lmsp_pkg::BYTE_W-1:0]    pixel_byte,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [lmsp_pkg::COLOR_W-1:0]   color_bits,
	output logic [lmsp_pkg::ROW_W-1:0]     row_address,
	output logic                           last
);

	lmsp_pkg::ctl_cmd_t   cmd;
	lmsp_pkg::dp_status_t status;

	lmsp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.op         (op),
		.status     (status),
		.item_stall (item_stall),
		.cmd        (cmd)
	);

	lmsp_datapath #(
		.COLUMNS (COLUMNS),
		.LEVELS  (LEVELS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.pixel_byte   (pixel_byte),
		.result_stall (result_stall),
		.status       (status),
		.result_valid (result_valid),
		.color_bits   (color_bits),
		.row_address  (row_address),
		.last         (last)
	);

endmodule
